// ===== design/accel_orientation_remap_macros.svh =====
// Assertion macros shared by the accel_orientation_remap RTL.
// Each macro expects clk and rst_n in scope of the module that uses it.
`ifndef ACCEL_ORIENTATION_REMAP_MACROS_SVH
`define ACCEL_ORIENTATION_REMAP_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AOR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define AOR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/aor_pkg.sv =====
// Types, constants and table functions for the accelerometer orientation remap.
// No dependencies; used by every module of the block.
package aor_pkg;

    localparam int IN_W      = 10;   // raw sample field width
    localparam int VEC_W     = 11;   // remapped axis, holds the negated minimum
    localparam int OUT_W     = 15;   // Q8 g result width
    localparam int CNT_W     = 16;   // sample counter width
    localparam int TRIG_W    = 16;   // Q14 cos/sin width
    localparam int FACE_W    = 3;
    localparam int IDX_W     = 5;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_LSB   = 2;
    localparam int PROD_W    = VEC_W + TRIG_W;   // one tilt product
    localparam int TILT_W    = PROD_W + 1;       // sum of two products
    localparam int Q_SHIFT   = 7;                // power-of-two part of 896 and of 128/7
    localparam int NUM_W     = 19;               // numerator of the divide by 7
    localparam int RP_W      = 2 * NUM_W;        // reciprocal product
    localparam int RECIP_SHIFT = 21;
    localparam int QUO_W     = RP_W - RECIP_SHIFT;

    localparam int ROM_ENTRIES = 24;
    localparam logic [IDX_W-1:0] FALLBACK_ENTRY = 5'd7;

    // ceil(2^21 / 7): exact floor(n / 7) for every numerator below 2^18 + 1
    localparam logic [NUM_W-1:0] RECIP_7 = 19'd299594;
    localparam logic [QUO_W-1:0] DIV_BASE = 17'd7;

    localparam logic signed [OUT_W-1:0] Q8_MAX = 15'sh3FFF;
    localparam logic signed [OUT_W-1:0] Q8_MIN = 15'sh4000;
    localparam logic [QUO_W-1:0] Q8_MAG_POS = 17'd16383;
    localparam logic [QUO_W-1:0] Q8_MAG_NEG = 17'd16384;

    // configuration register indexes
    localparam logic [2:0] REG_LOG_ENABLE  = 3'd0;
    localparam logic [2:0] REG_SENSOR_ORNT = 3'd1;
    localparam logic [2:0] REG_FWD_FACE    = 3'd2;
    localparam logic [2:0] REG_UP_FACE     = 3'd3;
    localparam logic [2:0] REG_MOUNT_COS   = 3'd4;
    localparam logic [2:0] REG_MOUNT_SIN   = 3'd5;

    typedef logic signed [VEC_W-1:0] axis_t;

    typedef struct packed {
        axis_t a0;
        axis_t a1;
        axis_t a2;
    } vec_t;

    // one row of a signed permutation: which element, and whether to negate it
    typedef struct packed {
        logic [1:0] col;
        logic       neg;
    } tap_t;

    typedef struct packed {
        tap_t t0;
        tap_t t1;
        tap_t t2;
    } perm_t;

    localparam logic [1:0] COL_0 = 2'd0;
    localparam logic [1:0] COL_1 = 2'd1;
    localparam logic [1:0] COL_2 = 2'd2;

    localparam tap_t XP = '{col: COL_0, neg: 1'b0};
    localparam tap_t XN = '{col: COL_0, neg: 1'b1};
    localparam tap_t YP = '{col: COL_1, neg: 1'b0};
    localparam tap_t YN = '{col: COL_1, neg: 1'b1};
    localparam tap_t ZP = '{col: COL_2, neg: 1'b0};
    localparam tap_t ZN = '{col: COL_2, neg: 1'b1};

    // (forward face, upward face) for each orientation entry
    localparam logic [2*FACE_W-1:0] FACE_PAIRS [ROM_ENTRIES] = '{
        6'o02, 6'o03, 6'o04, 6'o05, 6'o12, 6'o13, 6'o14, 6'o15,
        6'o20, 6'o21, 6'o24, 6'o25, 6'o30, 6'o31, 6'o34, 6'o35,
        6'o40, 6'o41, 6'o42, 6'o43, 6'o50, 6'o51, 6'o52, 6'o53
    };

    function automatic perm_t rom_entry(logic [IDX_W-1:0] idx);
        perm_t m;
        unique case (idx)
            5'd0:    m = '{XN, ZN, YN};
            5'd1:    m = '{XN, ZP, YP};
            5'd2:    m = '{XN, YP, ZN};
            5'd3:    m = '{XN, YN, ZP};
            5'd4:    m = '{XP, ZP, YN};
            5'd5:    m = '{XP, ZN, YP};
            5'd6:    m = '{XP, YN, ZN};
            5'd7:    m = '{XP, YP, ZP};
            5'd8:    m = '{YP, ZP, XP};
            5'd9:    m = '{YP, ZN, XN};
            5'd10:   m = '{YP, XP, ZN};
            5'd11:   m = '{YP, XN, ZP};
            5'd12:   m = '{YN, ZN, XP};
            5'd13:   m = '{YN, ZP, XN};
            5'd14:   m = '{YN, XN, ZN};
            5'd15:   m = '{YN, XP, ZP};
            5'd16:   m = '{ZP, YN, XP};
            5'd17:   m = '{ZP, YP, XN};
            5'd18:   m = '{ZP, XN, YN};
            5'd19:   m = '{ZP, XP, YP};
            5'd20:   m = '{ZN, YP, XP};
            5'd21:   m = '{ZN, YN, XN};
            5'd22:   m = '{ZN, XP, YN};
            5'd23:   m = '{ZN, XN, YP};
            default: m = '{XP, YP, ZP};
        endcase
        return m;
    endfunction

    function automatic axis_t tap_val(vec_t v, tap_t t);
        axis_t s;
        unique case (t.col)
            COL_0:   s = v.a0;
            COL_1:   s = v.a1;
            default: s = v.a2;
        endcase
        return t.neg ? -s : s;
    endfunction

    function automatic vec_t apply_perm(perm_t m, vec_t v);
        vec_t o;
        o.a0 = tap_val(v, m.t0);
        o.a1 = tap_val(v, m.t1);
        o.a2 = tap_val(v, m.t2);
        return o;
    endfunction

    // first entry whose face pair matches, else the fallback entry
    function automatic logic [IDX_W-1:0] unit_index(logic [FACE_W-1:0] fwd,
                                                    logic [FACE_W-1:0] up);
        logic [IDX_W-1:0] idx;
        idx = FALLBACK_ENTRY;
        for (int i = ROM_ENTRIES - 1; i >= 0; i--) begin
            if (FACE_PAIRS[i] == {fwd, up}) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // floor(num / 7) from the reciprocal product, with a one-step upward fix
    function automatic logic [QUO_W-1:0] div7_fix(logic [NUM_W-1:0] num,
                                                  logic [RP_W-1:0] rp);
        logic [QUO_W-1:0] q;
        logic [NUM_W:0]   q7;
        logic [NUM_W:0]   rem;
        q   = rp[RP_W-1:RECIP_SHIFT];
        q7  = (NUM_W+1)'({q, 3'b000}) - (NUM_W+1)'(q);
        rem = {1'b0, num} - q7;
        if (!rem[NUM_W] && (rem >= (NUM_W+1)'(DIV_BASE))) begin
            q = q + 1'b1;
        end
        return q;
    endfunction

    // apply sign to a magnitude quotient and clamp to the Q8 range
    function automatic logic signed [OUT_W-1:0] sat_q8(logic [QUO_W-1:0] q, logic neg);
        logic [QUO_W-1:0]        nq;
        logic signed [OUT_W-1:0] r;
        nq = QUO_W'(0) - q;
        if (neg) begin
            r = (q > Q8_MAG_NEG) ? Q8_MIN : nq[OUT_W-1:0];
        end else begin
            r = (q > Q8_MAG_POS) ? Q8_MAX : q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== design/aor_front.sv =====
// Front end: takes raw samples, drops them when logging is off, remaps the axes.
// Depends on aor_pkg for the orientation table and vector type.
module aor_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_x,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_y,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_z,
    input  logic                               log_enable,
    input  logic [aor_pkg::IDX_W-1:0]          sensor_orientation,
    input  logic [aor_pkg::FACE_W-1:0]         forward_face,
    input  logic [aor_pkg::FACE_W-1:0]         upward_face,
    output logic                               q_wr,
    output aor_pkg::vec_t                      q_data,
    input  logic                               q_full
);
    import aor_pkg::*;

    logic             front_valid_reg;
    logic             front_valid_next;
    vec_t             front_vec_reg;
    vec_t             raw_vec;
    vec_t             unit_vec;
    vec_t             veh_vec;
    axis_t            z_ext;
    logic [IDX_W-1:0] sidx;
    logic [IDX_W-1:0] uidx;
    logic             take;
    logic             accept;

    assign z_ext      = VEC_W'(accel_z);
    assign raw_vec.a0 = VEC_W'(accel_x);
    assign raw_vec.a1 = VEC_W'(accel_y);
    assign raw_vec.a2 = -z_ext;

    assign sidx = (sensor_orientation < IDX_W'(ROM_ENTRIES)) ? sensor_orientation
                                                             : FALLBACK_ENTRY;
    assign uidx = unit_index(forward_face, upward_face);

    assign unit_vec = apply_perm(rom_entry(sidx), raw_vec);
    assign veh_vec  = apply_perm(rom_entry(uidx), unit_vec);

    // hand the held beat on when the queue has room; refill in the same cycle
    assign take   = front_valid_reg && !q_full;
    assign full   = front_valid_reg && q_full;
    assign accept = push && !full;

    assign front_valid_next = (front_valid_reg && !take) || (accept && log_enable);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && log_enable)
        begin
            front_vec_reg <= veh_vec;
        end
    end

    assign q_wr   = take;
    assign q_data = front_vec_reg;

endmodule

// ===== design/aor_queue.sv =====
// Short queue of remapped vectors between the front end and the tilt/scale back end.
// Depends on aor_pkg for the vector type and on the shared assertion macros.
`include "accel_orientation_remap_macros.svh"

module aor_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  aor_pkg::vec_t wr_data,
    output logic          full,
    input  logic          rd,
    output aor_pkg::vec_t rd_data,
    output logic          empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(DEPTH);

    aor_pkg::vec_t    slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [LVL_W-1:0] level_reg;
    logic [LVL_W-1:0] level_next;

    assign full    = (level_reg == LVL_FULL);
    assign empty   = (level_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        level_next = level_reg;
        if (wr && !rd)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            level_reg <= level_next;
            if (wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `AOR_ASSERT_NOW(a_no_overfill, wr, !full || rd, "queue written while full")
    `AOR_ASSERT_NOW(a_no_underrun, rd, !empty, "queue read while empty")
    `AOR_ASSERT_NOW(a_level_bound, 1'b1, level_reg <= LVL_FULL, "queue level beyond depth")

endmodule

// ===== design/aor_back.sv =====
// Back end: mount-tilt rotation, divide to Q8 g, saturation, result register and counter.
// Depends on aor_pkg for arithmetic helpers and on the shared assertion macros.
`include "accel_orientation_remap_macros.svh"

module aor_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  aor_pkg::vec_t                       q_data,
    input  logic                                q_empty,
    output logic                                q_rd,
    input  logic signed [aor_pkg::TRIG_W-1:0]   mount_cos,
    input  logic signed [aor_pkg::TRIG_W-1:0]   mount_sin,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [aor_pkg::OUT_W-1:0]    forward_g,
    output logic signed [aor_pkg::OUT_W-1:0]    right_g,
    output logic signed [aor_pkg::OUT_W-1:0]    down_g,
    output logic [aor_pkg::CNT_W-1:0]           sample_number
);
    import aor_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TILT = 5'b00010,
        ST_DIVF = 5'b00100,
        ST_DIVD = 5'b01000,
        ST_DONE = 5'b10000
    } back_state_t;

    back_state_t state_reg;
    back_state_t state_next;

    axis_t                    fwd_reg;
    axis_t                    dn_reg;
    logic signed [PROD_W-1:0] p0_reg;
    logic signed [PROD_W-1:0] p1_reg;
    logic [RP_W-1:0]          rp_reg;
    logic [NUM_W-1:0]         nr_reg;
    logic [NUM_W-1:0]         nf_reg;
    logic [NUM_W-1:0]         nd_reg;
    logic                     neg_r_reg;
    logic                     neg_f_reg;
    logic                     neg_d_reg;
    logic [QUO_W-1:0]         qr_reg;
    logic [QUO_W-1:0]         qf_reg;

    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  fwd_g_reg;
    logic signed [OUT_W-1:0]  right_g_reg;
    logic signed [OUT_W-1:0]  down_g_reg;
    logic [CNT_W-1:0]         sample_cnt_reg;

    axis_t                    op_a0;
    axis_t                    op_a1;
    logic signed [TRIG_W-1:0] op_b0;
    logic signed [TRIG_W-1:0] op_b1;
    logic signed [PROD_W-1:0] mul0;
    logic signed [PROD_W-1:0] mul1;
    logic [NUM_W-1:0]         div_in;
    logic [RP_W-1:0]          rp_w;

    logic signed [TILT_W-1:0] tilt_f;
    logic signed [TILT_W-1:0] tilt_d;
    logic [TILT_W-1:0]        mag_f;
    logic [TILT_W-1:0]        mag_d;
    logic [VEC_W-1:0]         mag_r;
    logic [NUM_W-1:0]         num_r;
    logic                     load_out;

    // operand select for the two tilt multipliers
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            op_a0 = q_data.a0;
            op_b0 = mount_cos;
            op_a1 = q_data.a2;
            op_b1 = mount_sin;
        end
        else
        begin
            op_a0 = fwd_reg;
            op_b0 = mount_sin;
            op_a1 = dn_reg;
            op_b1 = mount_cos;
        end
    end

    assign mul0 = PROD_W'(op_a0) * PROD_W'(op_b0);
    assign mul1 = PROD_W'(op_a1) * PROD_W'(op_b1);

    // shared reciprocal multiplier: right, then forward, then down
    always_comb
    begin
        case (state_reg)
            ST_TILT: div_in = nr_reg;
            ST_DIVF: div_in = nf_reg;
            default: div_in = nd_reg;
        endcase
    end

    assign rp_w = RP_W'(div_in) * RP_W'(RECIP_7);

    assign tilt_f = TILT_W'(p0_reg) - TILT_W'(p1_reg);
    assign tilt_d = TILT_W'(p0_reg) + TILT_W'(p1_reg);
    assign mag_f  = tilt_f[TILT_W-1] ? TILT_W'(-tilt_f) : TILT_W'(tilt_f);
    assign mag_d  = tilt_d[TILT_W-1] ? TILT_W'(-tilt_d) : TILT_W'(tilt_d);
    assign mag_r  = q_data.a1[VEC_W-1] ? VEC_W'(-q_data.a1) : VEC_W'(q_data.a1);
    assign num_r  = NUM_W'({mag_r, {Q_SHIFT{1'b0}}});

    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || pop);
    assign q_rd     = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (!q_empty) state_next = ST_TILT;
            ST_TILT: state_next = ST_DIVF;
            ST_DIVF: state_next = ST_DIVD;
            ST_DIVD: state_next = ST_DONE;
            ST_DONE: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            sample_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg  <= 1'b1;
                sample_cnt_reg <= sample_cnt_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    fwd_reg   <= q_data.a0;
                    dn_reg    <= q_data.a2;
                    nr_reg    <= num_r;
                    neg_r_reg <= q_data.a1[VEC_W-1];
                    p0_reg    <= mul0;
                    p1_reg    <= mul1;
                end
            end
            ST_TILT:
            begin
                nf_reg    <= mag_f[NUM_W+Q_SHIFT-1:Q_SHIFT];
                neg_f_reg <= tilt_f[TILT_W-1];
                p0_reg    <= mul0;
                p1_reg    <= mul1;
                rp_reg    <= rp_w;
            end
            ST_DIVF:
            begin
                nd_reg    <= mag_d[NUM_W+Q_SHIFT-1:Q_SHIFT];
                neg_d_reg <= tilt_d[TILT_W-1];
                qr_reg    <= div7_fix(nr_reg, rp_reg);
                rp_reg    <= rp_w;
            end
            ST_DIVD:
            begin
                qf_reg <= div7_fix(nf_reg, rp_reg);
                rp_reg <= rp_w;
            end
            default:
            begin
                if (load_out)
                begin
                    fwd_g_reg   <= sat_q8(qf_reg, neg_f_reg);
                    right_g_reg <= sat_q8(qr_reg, neg_r_reg);
                    down_g_reg  <= sat_q8(div7_fix(nd_reg, rp_reg), neg_d_reg);
                end
            end
        endcase
    end

    assign empty         = !out_valid_reg;
    assign forward_g     = fwd_g_reg;
    assign right_g       = right_g_reg;
    assign down_g        = down_g_reg;
    assign sample_number = sample_cnt_reg;

    `AOR_ASSERT_NEXT(a_result_not_overwritten, (state_reg == ST_DONE) && out_valid_reg && !pop, state_reg == ST_DONE, "result register overwritten")
    `AOR_ASSERT_NEXT(a_count_per_result, load_out, sample_cnt_reg == CNT_W'($past(sample_cnt_reg) + 1'b1), "counter missed a result")

endmodule

// ===== design/accel_orientation_remap.sv =====
// accel_orientation_remap: accelerometer axis remap, mount tilt and Q8 g scaling.
// An accepted beat passes the front-end register, the queue and the back end's tilt,
// divide and done states; the back end takes a new beat only once its result is loaded.
// The front end takes a new beat every cycle while the queue has room.
// Reset (rst_n low, asynchronous): registers return to their reset values, queues empty,
// sample counter zero. Depends on aor_pkg, aor_front, aor_queue and aor_back.
module accel_orientation_remap #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [aor_pkg::ADDR_W-1:0]         paddr,
    input  logic [aor_pkg::DATA_W-1:0]         pwdata,
    output logic [aor_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // sample side
    input  logic                               push,
    output logic                               full,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_x,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_y,
    input  logic signed [aor_pkg::IN_W-1:0]    accel_z,
    // result side
    output logic                               empty,
    input  logic                               pop,
    output logic signed [aor_pkg::OUT_W-1:0]   forward_g,
    output logic signed [aor_pkg::OUT_W-1:0]   right_g,
    output logic signed [aor_pkg::OUT_W-1:0]   down_g,
    output logic [aor_pkg::CNT_W-1:0]          sample_number
);
    import aor_pkg::*;

    // configuration registers
    logic                     log_enable_reg;
    logic [IDX_W-1:0]         sensor_orientation_reg;
    logic [FACE_W-1:0]        forward_face_reg;
    logic [FACE_W-1:0]        upward_face_reg;
    logic signed [TRIG_W-1:0] mount_cos_reg;
    logic signed [TRIG_W-1:0] mount_sin_reg;

    logic                     cfg_wr;
    logic [2:0]               reg_sel;

    // front-to-back queue
    logic q_wr;
    logic q_full;
    logic q_rd;
    logic q_empty;
    vec_t q_wr_data;
    vec_t q_rd_data;

    // Register writes complete in the access phase; no wait states.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[ADDR_W-1:REG_LSB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_enable_reg         <= 1'b0;
            sensor_orientation_reg <= 5'd7;
            forward_face_reg       <= 3'd1;
            upward_face_reg        <= 3'd5;
            mount_cos_reg          <= 16'sh4000;
            mount_sin_reg          <= 16'sh0000;
        end
        else if (cfg_wr)
        begin
            // mask each write to the register's width; drop writes past the last register
            unique case (reg_sel)
                REG_LOG_ENABLE:  log_enable_reg         <= pwdata[0];
                REG_SENSOR_ORNT: sensor_orientation_reg <= pwdata[IDX_W-1:0];
                REG_FWD_FACE:    forward_face_reg       <= pwdata[FACE_W-1:0];
                REG_UP_FACE:     upward_face_reg        <= pwdata[FACE_W-1:0];
                REG_MOUNT_COS:   mount_cos_reg          <= pwdata[TRIG_W-1:0];
                REG_MOUNT_SIN:   mount_sin_reg          <= pwdata[TRIG_W-1:0];
                default:         ;
            endcase
        end
    end

    // read back the raw register bits, zero-extended
    always_comb
    begin
        unique case (reg_sel)
            REG_LOG_ENABLE:  prdata = DATA_W'(log_enable_reg);
            REG_SENSOR_ORNT: prdata = DATA_W'(sensor_orientation_reg);
            REG_FWD_FACE:    prdata = DATA_W'(forward_face_reg);
            REG_UP_FACE:     prdata = DATA_W'(upward_face_reg);
            REG_MOUNT_COS:   prdata = DATA_W'($unsigned(mount_cos_reg));
            REG_MOUNT_SIN:   prdata = DATA_W'($unsigned(mount_sin_reg));
            default:         prdata = '0;
        endcase
    end

    // Front end: drop beats while logging is off, remap sensor -> unit -> vehicle axes.
    aor_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .push               (push),
        .full               (full),
        .accel_x            (accel_x),
        .accel_y            (accel_y),
        .accel_z            (accel_z),
        .log_enable         (log_enable_reg),
        .sensor_orientation (sensor_orientation_reg),
        .forward_face       (forward_face_reg),
        .upward_face        (upward_face_reg),
        .q_wr               (q_wr),
        .q_data             (q_wr_data),
        .q_full             (q_full)
    );

    // Decouple the front end from the back end, which steps through its states for each beat.
    aor_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_data),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_rd_data),
        .empty   (q_empty)
    );

    // Back end: tilt by the mount angle, divide to Q8 g, saturate, hold the result.
    aor_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_rd_data),
        .q_empty       (q_empty),
        .q_rd          (q_rd),
        .mount_cos     (mount_cos_reg),
        .mount_sin     (mount_sin_reg),
        .empty         (empty),
        .pop           (pop),
        .forward_g     (forward_g),
        .right_g       (right_g),
        .down_g        (down_g),
        .sample_number (sample_number)
    );

endmodule
